[design/skpc_pkg.sv]
// shared types, constants and table builders for the soft-knee peak compressor
package skpc_pkg;

   localparam int FIELD_COUNT          = 8;
   localparam int MAX_CHANNELS_DEFAULT = 8;
   localparam int SAMPLE_BITS_DEFAULT  = 24;

   // configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 17;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RATIO     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KNEE      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ATTACK    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RELEASE   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAKEUP    = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WET       = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHANNELS  = 3'd7;

   localparam logic signed [15:0] THRESHOLD_RESET = -16'sd5120;
   localparam logic [14:0]        RATIO_RESET     = 15'd1024;
   localparam logic [12:0]        KNEE_RESET      = 13'd1536;
   localparam logic [15:0]        ATTACK_RESET    = 16'd0;
   localparam logic [15:0]        RELEASE_RESET   = 16'd0;
   localparam logic [15:0]        MAKEUP_RESET    = 16'd4096;
   localparam logic [16:0]        WET_RESET       = 17'd65536;
   localparam logic [3:0]         CHANNELS_RESET  = 4'd2;

   localparam logic [14:0]        RATIO_UNITY = 15'd256;
   localparam logic [16:0]        WET_FULL    = 17'd65536;

   // level and gain conversion
   localparam logic signed [17:0] FLOOR_DB     = -18'sd30720;
   localparam logic [31:0]        DB_PER_LOG2  = 32'd394566;
   localparam logic [31:0]        LOG2_PER_DB  = 32'd10885;
   localparam int                 GAIN_STEPS   = 16;
   localparam int                 FACTOR_BITS  = 31;

   // shared multiplier
   localparam int MUL_A_BITS = 36;
   localparam int MUL_B_BITS = 32;
   localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;

   typedef logic [MUL_A_BITS-1:0] mul_a_type;
   typedef logic [MUL_B_BITS-1:0] mul_b_type;
   typedef logic [MUL_P_BITS-1:0] mul_p_type;

   // shared divider
   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [15:0] divisor;
   } div_request_type;

   typedef struct packed {
      logic        done;
      logic [15:0] quotient;
   } div_status_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bit_v;
      rem   = v;
      res   = '0;
      bit_v = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (rem >= res + bit_v) begin
            rem = rem - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // factors 2^-(2^-i), i = 1..16, Q1.30, each the floor root of the one before
   function automatic logic [GAIN_STEPS*FACTOR_BITS-1:0] build_gain_factors();
      logic [63:0]                        s;
      logic [GAIN_STEPS*FACTOR_BITS-1:0] tab;
      s   = 64'd1 << 29;
      tab = '0;
      for (int i = 0; i < GAIN_STEPS; i++) begin
         s = isqrt64(s << 30);
         tab[i*FACTOR_BITS +: FACTOR_BITS] = s[FACTOR_BITS-1:0];
      end
      return tab;
   endfunction

   localparam logic [GAIN_STEPS*FACTOR_BITS-1:0] GAIN_FACTORS = build_gain_factors();

endpackage

[design/skpc_mul.sv]
// shared multiplier with registered product
module skpc_mul (
   input  logic                clock,
   input  skpc_pkg::mul_a_type a,
   input  skpc_pkg::mul_b_type b,
   output skpc_pkg::mul_p_type product
);
   import skpc_pkg::*;

   mul_p_type product_ff;
   mul_p_type product_in;

   assign product_in = MUL_P_BITS'(a) * MUL_P_BITS'(b);
   assign product    = product_ff;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

[design/skpc_div.sv]
// restoring divider, one quotient bit per cycle, 16-bit quotient
module skpc_div (
   input  logic                      clock,
   input  logic                      reset,
   input  skpc_pkg::div_request_type req,
   output skpc_pkg::div_status_type  status
);
   import skpc_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] dvd_ff, dvd_in;
   logic [15:0] dvr_ff, dvr_in;
   logic [15:0] q_ff, q_in;
   logic [16:0] trial;
   logic        fits;

   assign trial = {rem_ff, dvd_ff[15]};
   assign fits  = trial >= {1'b0, dvr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvr_in  = dvr_ff;
      q_in    = q_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = req.dividend[31:16];
         dvd_in  = req.dividend[15:0];
         dvr_in  = req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? 16'(trial - {1'b0, dvr_ff}) : trial[15:0];
         q_in   = {q_ff[14:0], fits};
         dvd_in = {dvd_ff[14:0], 1'b0};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvr_ff <= dvr_in;
      q_ff   <= q_in;
   end

   assign status.done     = done_ff;
   assign status.quotient = q_ff;

endmodule

[design/soft_knee_peak_compressor_core.sv]
// soft-knee peak compressor core: sequencer around one shared multiplier and divider
//
//   channel  direction  transfer when           carries
//   req_     in         req_valid & req_ready   one frame, silent and enabled flags
//   rsp_     out        rsp_valid & rsp_ready   processed frame, kept reduction
//   csr_     in         csr_valid & csr_ready   register index and data, always ready
//
// a bypassed frame goes straight to the output handover; an enabled frame runs the
// bit-serial normalize, the 16-pass log squaring and 16-pass gain product on the
// shared multiplier, the divider (slope, soft knee) and the per-channel steps
// reset is synchronous: state idle, kept reduction zero, registers at defaults
// req_ready is high only while idle; one finished frame waits in the output register
// while the next frame is taken, and a stalled rsp_ready holds the sequencer at its end
module soft_knee_peak_compressor_core #(
   parameter int MAX_CHANNELS = skpc_pkg::MAX_CHANNELS_DEFAULT,
   parameter int SAMPLE_BITS  = skpc_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_0,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_1,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_2,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_3,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_4,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_5,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_6,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_7,
   input  logic                                req_silent,
   input  logic                                req_enabled,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]       rsp_out_0,
   output logic signed [SAMPLE_BITS-1:0]       rsp_out_1,
   output logic signed [SAMPLE_BITS-1:0]       rsp_out_2,
   output logic signed [SAMPLE_BITS-1:0]       rsp_out_3,
   output logic signed [SAMPLE_BITS-1:0]       rsp_out_4,
   output logic signed [SAMPLE_BITS-1:0]       rsp_out_5,
   output logic signed [SAMPLE_BITS-1:0]       rsp_out_6,
   output logic signed [SAMPLE_BITS-1:0]       rsp_out_7,
   output logic [15:0]                         rsp_reduction_level,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [skpc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [skpc_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import skpc_pkg::*;

   localparam int SB       = SAMPLE_BITS;
   localparam int PH_BITS  = SB + 6;
   localparam int MAG_BITS = SB + 7;
   localparam logic [MAG_BITS-1:0] MAG_HALF = MAG_BITS'(1) << (SB - 1);
   localparam logic [3:0]          LAST_CH  = 4'(MAX_CHANNELS - 1);

   // sequencer states
   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_PEAK    = 5'd1;
   localparam logic [4:0] ST_NORM    = 5'd2;
   localparam logic [4:0] ST_LOGSQ   = 5'd3;
   localparam logic [4:0] ST_LOGACC  = 5'd4;
   localparam logic [4:0] ST_DBMUL   = 5'd5;
   localparam logic [4:0] ST_DBRES   = 5'd6;
   localparam logic [4:0] ST_SLOPE   = 5'd7;
   localparam logic [4:0] ST_SLOPEW  = 5'd8;
   localparam logic [4:0] ST_TGT     = 5'd9;
   localparam logic [4:0] ST_HARDRES = 5'd10;
   localparam logic [4:0] ST_SOFT1   = 5'd11;
   localparam logic [4:0] ST_SOFT2   = 5'd12;
   localparam logic [4:0] ST_SOFTW   = 5'd13;
   localparam logic [4:0] ST_SMOOTH  = 5'd14;
   localparam logic [4:0] ST_SMRES   = 5'd15;
   localparam logic [4:0] ST_EXP     = 5'd16;
   localparam logic [4:0] ST_EXPRES  = 5'd17;
   localparam logic [4:0] ST_GAINLP  = 5'd18;
   localparam logic [4:0] ST_GAINACC = 5'd19;
   localparam logic [4:0] ST_MKUP    = 5'd20;
   localparam logic [4:0] ST_MKRES   = 5'd21;
   localparam logic [4:0] ST_MIXRES  = 5'd22;
   localparam logic [4:0] ST_CHH     = 5'd23;
   localparam logic [4:0] ST_CHL     = 5'd24;
   localparam logic [4:0] ST_CHR     = 5'd25;
   localparam logic [4:0] ST_DONE    = 5'd26;

   // configuration registers
   logic signed [15:0] thr_ff;
   logic [14:0]        ratio_ff;
   logic [12:0]        knee_ff;
   logic [15:0]        attack_ff;
   logic [15:0]        release_ff;
   logic [15:0]        makeup_ff;
   logic [16:0]        wet_ff;
   logic [3:0]         chans_ff;

   // sequencer and work registers
   logic [4:0]           state_ff, state_in;
   logic [3:0]           cnt_ff, cnt_in;
   logic signed [SB-1:0] x_ff [FIELD_COUNT];
   logic signed [SB-1:0] x_in [FIELD_COUNT];
   logic signed [SB-1:0] res_ff [FIELD_COUNT];
   logic signed [SB-1:0] res_in [FIELD_COUNT];
   logic signed [SB-1:0] out_ff [FIELD_COUNT];
   logic signed [SB-1:0] out_in [FIELD_COUNT];
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [15:0]          red_out_ff, red_out_in;
   logic [15:0]          kept_ff, kept_in;
   logic [SB-1:0]        peak_ff, peak_in;
   logic [31:0]          norm_ff, norm_in;
   logic [4:0]           k_ff, k_in;
   logic [30:0]          m_ff, m_in;
   logic [15:0]          frac_ff, frac_in;
   logic signed [17:0]   db_ff, db_in;
   logic [15:0]          slope_ff, slope_in;
   logic [15:0]          target_ff, target_in;
   logic [21:0]          e_ff, e_in;
   logic [30:0]          r_ff, r_in;
   logic [35:0]          mix_ff, mix_in;
   logic [PH_BITS-1:0]   ph_ff, ph_in;

   // shared units
   mul_a_type       mul_a;
   mul_b_type       mul_b;
   mul_p_type       prod;
   div_request_type div_req;
   div_status_type  div_st;

   skpc_mul u_mul (
      .clock   (clock),
      .a       (mul_a),
      .b       (mul_b),
      .product (prod)
   );

   skpc_div u_div (
      .clock  (clock),
      .reset  (reset),
      .req    (div_req),
      .status (div_st)
   );

   // port gathering
   logic signed [SB-1:0] sample_in [FIELD_COUNT];
   assign sample_in[0] = req_sample_0;
   assign sample_in[1] = req_sample_1;
   assign sample_in[2] = req_sample_2;
   assign sample_in[3] = req_sample_3;
   assign sample_in[4] = req_sample_4;
   assign sample_in[5] = req_sample_5;
   assign sample_in[6] = req_sample_6;
   assign sample_in[7] = req_sample_7;

   assign rsp_out_0 = out_ff[0];
   assign rsp_out_1 = out_ff[1];
   assign rsp_out_2 = out_ff[2];
   assign rsp_out_3 = out_ff[3];
   assign rsp_out_4 = out_ff[4];
   assign rsp_out_5 = out_ff[5];
   assign rsp_out_6 = out_ff[6];
   assign rsp_out_7 = out_ff[7];
   assign rsp_reduction_level = red_out_ff;
   assign rsp_valid = rsp_valid_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   // channel count clamped into 1..MAX_CHANNELS
   logic [3:0] n_eff;
   assign n_eff = (chans_ff == 4'd0) ? 4'd1 :
                  ((chans_ff > 4'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS) : chans_ff);

   // current channel magnitude
   logic signed [SB-1:0] cur_x;
   logic                 cur_neg;
   logic [SB-1:0]        cur_abs;
   logic [SB-1:0]        peak_max;
   assign cur_x    = x_ff[cnt_ff[2:0]];
   assign cur_neg  = cur_x[SB-1];
   assign cur_abs  = cur_neg ? SB'(-cur_x) : SB'(cur_x);
   assign peak_max = (cur_abs > peak_ff) ? cur_abs : peak_ff;

   // log2 magnitude below full scale, Q.16
   logic [4:0]  lvl_shift;
   logic [20:0] neg_lvl;
   assign lvl_shift = k_ff - 5'(32 - SB);
   assign neg_lvl   = (lvl_shift == 5'd0) ? 21'd0 : ({lvl_shift, 16'h0} - 21'(frac_ff));

   // gain computer decisions
   logic signed [17:0] over;
   logic signed [19:0] tsum;
   logic signed [19:0] knee_s;
   logic signed [19:0] knee2_s;
   logic               soft_zero, soft_full, hard_sel, soft_sel;
   assign over      = db_ff - 18'(thr_ff);
   assign knee_s    = $signed({7'd0, knee_ff});
   assign knee2_s   = $signed({6'd0, knee_ff, 1'b0});
   assign tsum      = 20'(over) + 20'(over) + knee_s;
   assign soft_zero = (tsum <= 20'sd0);
   assign soft_full = (tsum >= knee2_s);
   assign hard_sel  = (knee_ff == 13'd0) ? (over > 18'sd0) : (!soft_zero && soft_full);
   assign soft_sel  = (knee_ff != 13'd0) && !soft_zero && !soft_full;

   // smoothing direction
   logic up;
   assign up = target_ff > kept_ff;

   // gain after integer shift
   logic [5:0]  e_int;
   logic [15:0] e_frac;
   logic [30:0] gain;
   assign e_int  = e_ff[21:16];
   assign e_frac = e_ff[15:0];
   assign gain   = (e_int >= 6'd31) ? 31'd0 : (r_ff >> e_int);

   // wet share saturated to one
   logic [16:0] wet_eff;
   logic [16:0] dry;
   assign wet_eff = (wet_ff > WET_FULL) ? WET_FULL : wet_ff;
   assign dry     = WET_FULL - wet_eff;

   // product slices
   logic [31:0]         sq;
   logic [40:0]         db_rnd;
   logic [16:0]         db_mag;
   logic [30:0]         e_sum;
   logic [51:0]         mix_sum;
   logic [62:0]         lo_sum;
   logic [MAG_BITS-1:0] mag;
   logic [MAG_BITS-1:0] mag_sat;
   logic [SB-1:0]       mag_pos;
   logic signed [SB-1:0] ch_out;
   assign sq      = prod[61:30];
   assign db_rnd  = 41'(prod[39:0]) + 41'(24'h80_0000);
   assign db_mag  = db_rnd[40:24];
   assign e_sum   = 31'(prod[29:0]) + 31'd128;
   assign mix_sum = 52'({dry, 30'd0}) + 52'(prod[50:0]);
   assign lo_sum  = 63'(prod[61:0]) + 63'(32'h2000_0000);
   assign mag     = MAG_BITS'(ph_ff) + MAG_BITS'(lo_sum[62:30]);
   assign mag_sat = (mag > MAG_HALF) ? MAG_HALF : mag;
   // positive side stops one below half scale, negative side reaches it
   assign mag_pos = (mag_sat == MAG_HALF) ? SB'(MAG_HALF - MAG_BITS'(1)) : SB'(mag_sat);
   assign ch_out  = cur_neg ? SB'(-SB'(mag_sat)) : mag_pos;

   // operand steering for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_LOGSQ: begin
            mul_a = MUL_A_BITS'(m_ff);
            mul_b = MUL_B_BITS'(m_ff);
         end
         ST_DBMUL: begin
            mul_a = MUL_A_BITS'(neg_lvl);
            mul_b = DB_PER_LOG2;
         end
         ST_TGT: begin
            if (hard_sel) begin
               mul_a = MUL_A_BITS'(over[16:0]);
               mul_b = MUL_B_BITS'(slope_ff);
            end else begin
               mul_a = MUL_A_BITS'(tsum[13:0]);
               mul_b = MUL_B_BITS'(tsum[13:0]);
            end
         end
         ST_SOFT1: begin
            mul_a = MUL_A_BITS'(prod[27:0]);
            mul_b = MUL_B_BITS'(slope_ff);
         end
         ST_SMOOTH: begin
            if (up) begin
               mul_a = MUL_A_BITS'(target_ff - kept_ff);
               mul_b = MUL_B_BITS'(attack_ff);
            end else begin
               mul_a = MUL_A_BITS'(kept_ff - target_ff);
               mul_b = MUL_B_BITS'(release_ff);
            end
         end
         ST_EXP: begin
            mul_a = MUL_A_BITS'(kept_ff);
            mul_b = LOG2_PER_DB;
         end
         ST_GAINLP: begin
            mul_a = MUL_A_BITS'(r_ff);
            mul_b = MUL_B_BITS'(GAIN_FACTORS[cnt_ff*FACTOR_BITS +: FACTOR_BITS]);
         end
         ST_MKUP: begin
            mul_a = MUL_A_BITS'(gain);
            mul_b = MUL_B_BITS'(makeup_ff);
         end
         ST_MKRES: begin
            mul_a = MUL_A_BITS'(prod[45:12]);
            mul_b = MUL_B_BITS'(wet_eff);
         end
         ST_CHH: begin
            mul_a = MUL_A_BITS'(cur_abs);
            mul_b = MUL_B_BITS'(mix_ff[35:30]);
         end
         ST_CHL: begin
            mul_a = MUL_A_BITS'(cur_abs);
            mul_b = MUL_B_BITS'(mix_ff[29:0]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // divider requests: slope from the ratio, then the soft-knee quotient
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      if (state_ff == ST_SLOPE) begin
         div_req.start    = (ratio_ff > RATIO_UNITY);
         div_req.dividend = 32'({15'(ratio_ff - RATIO_UNITY), 16'h0});
         div_req.divisor  = 16'(ratio_ff);
      end else if (state_ff == ST_SOFT2) begin
         div_req.start    = 1'b1;
         div_req.dividend = 32'(prod[43:19]);
         div_req.divisor  = 16'(knee_ff);
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      x_in         = x_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      red_out_in   = red_out_ff;
      kept_in      = kept_ff;
      peak_in      = peak_ff;
      norm_in      = norm_ff;
      k_in         = k_ff;
      m_in         = m_ff;
      frac_in      = frac_ff;
      db_in        = db_ff;
      slope_in     = slope_ff;
      target_in    = target_ff;
      e_in         = e_ff;
      r_in         = r_ff;
      mix_in       = mix_ff;
      ph_in        = ph_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // silent and inactive channels enter as zero
               for (int j = 0; j < FIELD_COUNT; j++) begin
                  x_in[j]   = (req_silent || (4'(j) >= n_eff)) ? '0 : sample_in[j];
                  res_in[j] = x_in[j];
               end
               peak_in = '0;
               cnt_in  = '0;
               if (req_enabled) begin
                  state_in = ST_PEAK;
               end else begin
                  kept_in  = '0;
                  state_in = ST_DONE;
               end
            end
         end
         ST_PEAK: begin
            peak_in = peak_max;
            cnt_in  = cnt_ff + 4'd1;
            if (cnt_ff == LAST_CH) begin
               if (peak_max == '0) begin
                  db_in    = FLOOR_DB;
                  state_in = ST_SLOPE;
               end else begin
                  norm_in  = 32'(peak_max);
                  k_in     = '0;
                  state_in = ST_NORM;
               end
            end
         end
         ST_NORM: begin
            if (norm_ff[31]) begin
               m_in     = norm_ff[31:1];
               frac_in  = '0;
               cnt_in   = '0;
               state_in = ST_LOGSQ;
            end else begin
               norm_in = {norm_ff[30:0], 1'b0};
               k_in    = k_ff + 5'd1;
            end
         end
         ST_LOGSQ: begin
            state_in = ST_LOGACC;
         end
         ST_LOGACC: begin
            frac_in = {frac_ff[14:0], sq[31]};
            m_in    = sq[31] ? sq[31:1] : sq[30:0];
            cnt_in  = cnt_ff + 4'd1;
            state_in = (cnt_ff == 4'd15) ? ST_DBMUL : ST_LOGSQ;
         end
         ST_DBMUL: begin
            state_in = ST_DBRES;
         end
         ST_DBRES: begin
            db_in    = -$signed({1'b0, db_mag});
            state_in = ST_SLOPE;
         end
         ST_SLOPE: begin
            if (ratio_ff > RATIO_UNITY) begin
               state_in = ST_SLOPEW;
            end else begin
               target_in = '0;
               state_in  = ST_SMOOTH;
            end
         end
         ST_SLOPEW: begin
            if (div_st.done) begin
               slope_in = div_st.quotient;
               state_in = ST_TGT;
            end
         end
         ST_TGT: begin
            if (hard_sel) begin
               state_in = ST_HARDRES;
            end else if (soft_sel) begin
               state_in = ST_SOFT1;
            end else begin
               target_in = '0;
               state_in  = ST_SMOOTH;
            end
         end
         ST_HARDRES: begin
            target_in = prod[32] ? 16'hFFFF : prod[31:16];
            state_in  = ST_SMOOTH;
         end
         ST_SOFT1: begin
            state_in = ST_SOFT2;
         end
         ST_SOFT2: begin
            state_in = ST_SOFTW;
         end
         ST_SOFTW: begin
            if (div_st.done) begin
               target_in = div_st.quotient;
               state_in  = ST_SMOOTH;
            end
         end
         ST_SMOOTH: begin
            state_in = ST_SMRES;
         end
         ST_SMRES: begin
            kept_in  = up ? (target_ff - prod[31:16]) : (target_ff + prod[31:16]);
            state_in = ST_EXP;
         end
         ST_EXP: begin
            state_in = ST_EXPRES;
         end
         ST_EXPRES: begin
            e_in     = e_sum[29:8];
            r_in     = 31'h4000_0000;
            cnt_in   = '0;
            state_in = ST_GAINLP;
         end
         ST_GAINLP: begin
            // bit for factor i is fraction bit 16-i, msb first
            if (e_frac[~cnt_ff]) begin
               state_in = ST_GAINACC;
            end else if (cnt_ff == 4'd15) begin
               state_in = ST_MKUP;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_GAINACC: begin
            r_in = prod[60:30];
            if (cnt_ff == 4'd15) begin
               state_in = ST_MKUP;
            end else begin
               cnt_in   = cnt_ff + 4'd1;
               state_in = ST_GAINLP;
            end
         end
         ST_MKUP: begin
            state_in = ST_MKRES;
         end
         ST_MKRES: begin
            state_in = ST_MIXRES;
         end
         ST_MIXRES: begin
            mix_in   = mix_sum[51:16];
            cnt_in   = '0;
            state_in = ST_CHH;
         end
         ST_CHH: begin
            state_in = ST_CHL;
         end
         ST_CHL: begin
            ph_in    = prod[PH_BITS-1:0];
            state_in = ST_CHR;
         end
         ST_CHR: begin
            res_in[cnt_ff[2:0]] = ch_out;
            if (cnt_ff == LAST_CH) begin
               state_in = ST_DONE;
            end else begin
               cnt_in   = cnt_ff + 4'd1;
               state_in = ST_CHH;
            end
         end
         ST_DONE: begin
            // hand over once the output register is free or being emptied
            if (!rsp_valid_ff || rsp_ready) begin
               out_in       = res_ff;
               red_out_in   = kept_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         kept_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         kept_ff      <= kept_in;
      end
      cnt_ff     <= cnt_in;
      x_ff       <= x_in;
      res_ff     <= res_in;
      out_ff     <= out_in;
      red_out_ff <= red_out_in;
      peak_ff    <= peak_in;
      norm_ff    <= norm_in;
      k_ff       <= k_in;
      m_ff       <= m_in;
      frac_ff    <= frac_in;
      db_ff      <= db_in;
      slope_ff   <= slope_in;
      target_ff  <= target_in;
      e_ff       <= e_in;
      r_ff       <= r_in;
      mix_ff     <= mix_in;
      ph_ff      <= ph_in;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff     <= THRESHOLD_RESET;
         ratio_ff   <= RATIO_RESET;
         knee_ff    <= KNEE_RESET;
         attack_ff  <= ATTACK_RESET;
         release_ff <= RELEASE_RESET;
         makeup_ff  <= MAKEUP_RESET;
         wet_ff     <= WET_RESET;
         chans_ff   <= CHANNELS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_THRESHOLD: thr_ff     <= $signed(csr_data[15:0]);
            CSR_RATIO:     ratio_ff   <= csr_data[14:0];
            CSR_KNEE:      knee_ff    <= csr_data[12:0];
            CSR_ATTACK:    attack_ff  <= csr_data[15:0];
            CSR_RELEASE:   release_ff <= csr_data[15:0];
            CSR_MAKEUP:    makeup_ff  <= csr_data[15:0];
            CSR_WET:       wet_ff     <= csr_data[16:0];
            CSR_CHANNELS:  chans_ff   <= csr_data[3:0];
            default: begin
            end
         endcase
      end
   end

endmodule
